### hw/rtl/ddo_pkg.sv
// ddo_pkg: shared types, constants and tables for the wheel odometry block
// no dependencies
`default_nettype none

package ddo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);

	// angles in q4.28 radians
	localparam logic [31:0] TWO_PI_Q  = 32'd1686629713;
	localparam logic [31:0] PI_Q      = 32'd843314857;
	localparam logic [31:0] HALF_PI_Q = 32'd421657428;
	localparam logic [31:0] GAIN_Q30  = 32'd652032874;

	localparam logic [27:0] DPT_RESET = 28'd8388608;
	localparam logic [31:0] ITW_RESET = 32'd21474836;

	localparam int          CFG_IDX_W           = 4;
	localparam logic [3:0]  REG_DIST_PER_TICK   = 4'd0;
	localparam logic [3:0]  REG_INV_TRACK_WIDTH = 4'd1;

	// datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_MDL  = 4'd2;
	localparam logic [3:0] OP_MDR  = 4'd3;
	localparam logic [3:0] OP_SUM  = 4'd4;
	localparam logic [3:0] OP_MTLO = 4'd5;
	localparam logic [3:0] OP_MTHI = 4'd6;
	localparam logic [3:0] OP_DTH  = 4'd7;
	localparam logic [3:0] OP_CORD = 4'd8;
	localparam logic [3:0] OP_MXLO = 4'd9;
	localparam logic [3:0] OP_MXHI = 4'd10;
	localparam logic [3:0] OP_XFIN = 4'd11;
	localparam logic [3:0] OP_MYLO = 4'd12;
	localparam logic [3:0] OP_MYHI = 4'd13;
	localparam logic [3:0] OP_YFIN = 4'd14;
	localparam logic [3:0] OP_OUT  = 4'd15;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic signed [31:0] heading;
		logic signed [39:0] step_distance;
	} out_item_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [ITER_W-1:0] iter;
	} ddo_cmd_t;

	typedef struct packed {
		logic mode;
	} ddo_status_t;

	function automatic logic [31:0] atan_q28(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h0C90FDAA;
			5'd1:  r = 32'h076B19C1;
			5'd2:  r = 32'h03EB6EBF;
			5'd3:  r = 32'h01FD5BA9;
			5'd4:  r = 32'h00FFAADD;
			5'd5:  r = 32'h007FF556;
			5'd6:  r = 32'h003FFEAA;
			5'd7:  r = 32'h001FFFD5;
			5'd8:  r = 32'h000FFFFA;
			5'd9:  r = 32'h0007FFFF;
			5'd10: r = 32'h0003FFFF;
			5'd11: r = 32'h0001FFFF;
			5'd12: r = 32'h0000FFFF;
			5'd13: r = 32'h00007FFF;
			5'd14: r = 32'h00003FFF;
			5'd15: r = 32'h00001FFF;
			5'd16: r = 32'h00000FFF;
			5'd17: r = 32'h000007FF;
			5'd18: r = 32'h000003FF;
			5'd19: r = 32'h000001FF;
			5'd20: r = 32'h000000FF;
			5'd21: r = 32'h0000007F;
			5'd22: r = 32'h0000003F;
			5'd23: r = 32'h0000001F;
			5'd24: r = 32'h0000000F;
			5'd25: r = 32'h00000007;
			5'd26: r = 32'h00000003;
			5'd27: r = 32'h00000002;
			5'd28: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ddo_ctrl.sv
// ddo_ctrl: sequencer for one odometry step, input and output handshakes
// depends on ddo_pkg
`default_nettype none

module ddo_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire                 out_stall,
	input  wire ddo_pkg::ddo_status_t st,
	output ddo_pkg::ddo_cmd_t    cmd
);
	import ddo_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MDL  = 4'd1;
	localparam logic [3:0] ST_MDR  = 4'd2;
	localparam logic [3:0] ST_SUM  = 4'd3;
	localparam logic [3:0] ST_MTLO = 4'd4;
	localparam logic [3:0] ST_MTHI = 4'd5;
	localparam logic [3:0] ST_DTH  = 4'd6;
	localparam logic [3:0] ST_CORD = 4'd7;
	localparam logic [3:0] ST_MXLO = 4'd8;
	localparam logic [3:0] ST_MXHI = 4'd9;
	localparam logic [3:0] ST_XFIN = 4'd10;
	localparam logic [3:0] ST_MYLO = 4'd11;
	localparam logic [3:0] ST_MYHI = 4'd12;
	localparam logic [3:0] ST_YFIN = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0]        state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              iter_last;

	assign iter_last = (iter_q == ITER_W'(CORDIC_STEPS - 1));
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.iter = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = st.mode ? ST_OUT : ST_MDL;
				end
			end
			ST_MDL:  begin cmd.op = OP_MDL;  state_d = ST_MDR;  end
			ST_MDR:  begin cmd.op = OP_MDR;  state_d = ST_SUM;  end
			ST_SUM:  begin cmd.op = OP_SUM;  state_d = ST_MTLO; end
			ST_MTLO: begin cmd.op = OP_MTLO; state_d = ST_MTHI; end
			ST_MTHI: begin cmd.op = OP_MTHI; state_d = ST_DTH;  end
			ST_DTH:  begin cmd.op = OP_DTH;  state_d = ST_CORD; end
			ST_CORD: begin
				cmd.op = OP_CORD;
				if (iter_last) begin
					state_d = ST_MXLO;
				end
			end
			ST_MXLO: begin cmd.op = OP_MXLO; state_d = ST_MXHI; end
			ST_MXHI: begin cmd.op = OP_MXHI; state_d = ST_XFIN; end
			ST_XFIN: begin cmd.op = OP_XFIN; state_d = ST_MYLO; end
			ST_MYLO: begin cmd.op = OP_MYLO; state_d = ST_MYHI; end
			ST_MYHI: begin cmd.op = OP_MYHI; state_d = ST_YFIN; end
			ST_YFIN: begin cmd.op = OP_YFIN; state_d = ST_OUT;  end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CORD) begin
				iter_q <= iter_last ? '0 : iter_q + 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ddo_datapath.sv
// ddo_datapath: pose state, config registers, shared multiplier, cordic, result register
// depends on ddo_pkg
`default_nettype none

module ddo_datapath (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ddo_pkg::ddo_cmd_t   cmd,
	output ddo_pkg::ddo_status_t     st,
	input  wire ddo_pkg::in_item_t   in_data,
	output ddo_pkg::out_item_t       out_data,
	input  wire                      cfg_we,
	input  wire [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]               cfg_data
);
	import ddo_pkg::*;

	logic [27:0] dpt_q;
	logic [31:0] itw_q;

	logic [31:0] last_left_q, last_right_q;
	logic signed [47:0] x_acc_q, y_acc_q;
	logic signed [31:0] theta_q;

	logic [31:0] tl_mag_q, tr_mag_q;
	logic        tl_neg_q, tr_neg_q;
	logic [63:0] prod_q, lp_q;
	logic signed [60:0] dl_q;
	logic [60:0] diff_mag_q;
	logic        diff_neg_q;
	logic signed [39:0] travel_q;
	logic signed [31:0] dth_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic        flip_q;
	out_item_t   out_q;

	// load
	logic [31:0] tl, tr;
	// multiplier operands
	logic [31:0] mul_a, mul_b;
	// sum and difference
	logic signed [60:0] p61, dr_c, sum_c, diff_c, sh_c;
	logic signed [39:0] travel_c;
	// fold
	logic signed [32:0] t0, t1;
	logic        flip_c;
	// heading change
	logic [67:0] rth;
	logic signed [31:0] dth_c;
	logic signed [32:0] th_sum, th_c;
	// cordic step
	logic signed [33:0] sx, sy;
	logic signed [32:0] at;
	// position increment
	logic        use_y;
	logic signed [33:0] trig_raw, trig;
	logic [31:0] trig_mag;
	logic [39:0] t_mag;
	logic        inc_neg;
	logic [65:0] rp;
	logic [48:0] rp_cap;
	logic signed [48:0] inc, acc_ext, acc_sum;
	logic signed [47:0] acc_new;

	assign st.mode  = in_data.mode;
	assign out_data = out_q;

	always_comb begin
		tl = in_data.left_count - last_left_q;
		tr = in_data.right_count - last_right_q;
	end

	// operand select for the shared 32x32 multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MDL:  begin mul_a = tl_mag_q; mul_b = {4'b0, dpt_q}; end
			OP_MDR:  begin mul_a = tr_mag_q; mul_b = {4'b0, dpt_q}; end
			OP_MTLO: begin mul_a = diff_mag_q[31:0]; mul_b = itw_q; end
			OP_MTHI: begin mul_a = {3'b0, diff_mag_q[60:32]}; mul_b = itw_q; end
			OP_MXLO, OP_MYLO: begin mul_a = t_mag[31:0]; mul_b = trig_mag; end
			OP_MXHI, OP_MYHI: begin mul_a = {24'b0, t_mag[39:32]}; mul_b = trig_mag; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// wheel distances, travel, heading change magnitude, cordic start
	always_comb begin
		p61    = $signed(prod_q[60:0]);
		dr_c   = tr_neg_q ? -p61 : p61;
		sum_c  = dr_c + dl_q;
		diff_c = dr_c - dl_q;
		sh_c   = sum_c >>> 9;
		if (sh_c > 61'sd549755813887) begin
			travel_c = 40'sh7FFFFFFFFF;
		end else if (sh_c < -61'sd549755813888) begin
			travel_c = -40'sh8000000000;
		end else begin
			travel_c = sh_c[39:0];
		end

		t0 = {theta_q[31], theta_q};
		if (t0 > $signed({1'b0, PI_Q})) begin
			t0 = t0 - $signed({1'b0, TWO_PI_Q});
		end else if (t0 < -$signed({1'b0, PI_Q})) begin
			t0 = t0 + $signed({1'b0, TWO_PI_Q});
		end
		flip_c = 1'b0;
		t1     = t0;
		if (t0 > $signed({1'b0, HALF_PI_Q})) begin
			t1     = t0 - $signed({1'b0, PI_Q});
			flip_c = 1'b1;
		end else if (t0 < -$signed({1'b0, HALF_PI_Q})) begin
			t1     = t0 + $signed({1'b0, PI_Q});
			flip_c = 1'b1;
		end
	end

	// heading change with its magnitude capped at 2*pi, then wrapped heading
	always_comb begin
		rth = {prod_q, 4'b0} + 68'(lp_q[63:28]);
		if (rth > 68'(TWO_PI_Q)) begin
			rth = 68'(TWO_PI_Q);
		end
		dth_c  = diff_neg_q ? -$signed(rth[31:0]) : $signed(rth[31:0]);
		th_sum = {theta_q[31], theta_q} + {dth_q[31], dth_q};
		th_c   = th_sum;
		if (th_sum >= $signed({1'b0, TWO_PI_Q})) begin
			th_c = th_sum - $signed({1'b0, TWO_PI_Q});
		end else if (th_sum <= -$signed({1'b0, TWO_PI_Q})) begin
			th_c = th_sum + $signed({1'b0, TWO_PI_Q});
		end
	end

	always_comb begin
		sx = cx_q >>> cmd.iter;
		sy = cy_q >>> cmd.iter;
		at = $signed({1'b0, atan_q28(5'(cmd.iter))});
	end

	// position increment: travel * trig >> 30 toward zero, capped at 2^47
	always_comb begin
		use_y    = (cmd.op == OP_MYLO) || (cmd.op == OP_MYHI) || (cmd.op == OP_YFIN);
		trig_raw = use_y ? cy_q : cx_q;
		trig     = flip_q ? -trig_raw : trig_raw;
		trig_mag = trig[33] ? 32'(-trig) : trig[31:0];
		t_mag    = travel_q[39] ? 40'(-travel_q) : travel_q;
		inc_neg  = travel_q[39] != trig[33];
		rp       = {prod_q, 2'b0} + 66'(lp_q[63:30]);
		rp_cap   = (rp > 66'(49'h0800000000000)) ? 49'h0800000000000 : rp[48:0];
		inc      = inc_neg ? -$signed(rp_cap) : $signed(rp_cap);
		acc_ext  = use_y ? {y_acc_q[47], y_acc_q} : {x_acc_q[47], x_acc_q};
		acc_sum  = acc_ext + inc;
		if (acc_sum > 49'sh07FFFFFFFFFFF) begin
			acc_new = 48'sh7FFFFFFFFFFF;
		end else if (acc_sum < -49'sh0800000000000) begin
			acc_new = -48'sh800000000000;
		end else begin
			acc_new = acc_sum[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q        <= DPT_RESET;
			itw_q        <= ITW_RESET;
			last_left_q  <= '0;
			last_right_q <= '0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			theta_q      <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_DIST_PER_TICK) begin
				dpt_q <= cfg_data[27:0];
			end
			if (cfg_we && cfg_index == REG_INV_TRACK_WIDTH) begin
				itw_q <= cfg_data;
			end
			if (cmd.op == OP_LOAD) begin
				last_left_q  <= in_data.left_count;
				last_right_q <= in_data.right_count;
				if (in_data.mode) begin
					x_acc_q <= '0;
					y_acc_q <= '0;
					theta_q <= '0;
				end
			end
			if (cmd.op == OP_XFIN) begin
				x_acc_q <= acc_new;
			end
			if (cmd.op == OP_YFIN) begin
				y_acc_q <= acc_new;
				theta_q <= th_c[31:0];
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_LOAD: begin
				tl_neg_q <= tl[31];
				tr_neg_q <= tr[31];
				tl_mag_q <= tl[31] ? -tl : tl;
				tr_mag_q <= tr[31] ? -tr : tr;
				if (in_data.mode) begin
					travel_q <= '0;
				end
			end
			OP_MDR: begin
				dl_q <= tl_neg_q ? -p61 : p61;
			end
			OP_SUM: begin
				travel_q   <= travel_c;
				diff_neg_q <= diff_c[60];
				diff_mag_q <= diff_c[60] ? 61'(-diff_c) : 61'(diff_c);
				cx_q       <= 34'(GAIN_Q30);
				cy_q       <= '0;
				cz_q       <= t1;
				flip_q     <= flip_c;
			end
			OP_MTHI, OP_MXHI, OP_MYHI: begin
				lp_q <= prod_q;
			end
			OP_DTH: begin
				dth_q <= dth_c;
			end
			OP_CORD: begin
				if (!cz_q[32]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + at;
				end
			end
			OP_OUT: begin
				out_q.pos_x         <= x_acc_q;
				out_q.pos_y         <= y_acc_q;
				out_q.heading       <= theta_q;
				out_q.step_distance <= travel_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/differential_drive_odometry.sv
// differential_drive_odometry: wheel encoder odometry, one result beat per input beat.
// a new input beat is taken only in the idle state, after the previous step has finished; the
// step is set by the 24 serial cordic iterations and eight passes through the single shared
// 32x32 multiplier (a pose reset goes straight to the result state); a stalled result
// holds the next one back until it is taken.
// reset: pose, last counts and config registers return to defaults; no clearing pass.
// depends on ddo_pkg, ddo_ctrl, ddo_datapath
`default_nettype none

module differential_drive_odometry (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire ddo_pkg::in_item_t       in_data,
	output logic                         out_valid,
	input  wire                          out_stall,
	output ddo_pkg::out_item_t           out_data,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]                   cfg_data
);
	import ddo_pkg::*;

	ddo_cmd_t    cmd;
	ddo_status_t st;

	assign cfg_ready = 1'b1;

	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ddo_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

### test/tb_differential_drive_odometry.sv
// tb_differential_drive_odometry: regression for the wheel odometry block
// predicts pose and travel in-line, checks every result beat; depends on ddo_pkg
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
	import ddo_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	differential_drive_odometry i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [27:0] dpt;
	logic [31:0] itw;
	longint last_l, last_r, x_pos, y_pos, theta;
	out_item_t pose_q[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_cnt;
	int idle_cycles;
	bit all_sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint sat_w(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// (a*b) >>> s toward zero, magnitude capped; 128-bit product is exact
	function automatic longint mul_shift_cap(longint a, longint b, int s, longint cap);
		logic signed [127:0] p;
		logic [127:0] m;
		bit neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p < 0;
		m = neg ? 128'(-p) : 128'(p);
		m = m >> s;
		if (m > 128'(cap))
			m = 128'(cap);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] arctan_q28(int i);
		logic [31:0] t[0:28] = '{
			32'h0C90FDAA, 32'h076B19C1, 32'h03EB6EBF, 32'h01FD5BA9, 32'h00FFAADD,
			32'h007FF556, 32'h003FFEAA, 32'h001FFFD5, 32'h000FFFFA, 32'h0007FFFF,
			32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF,
			32'h00001FFF, 32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF,
			32'h000000FF, 32'h0000007F, 32'h0000003F, 32'h0000001F, 32'h0000000F,
			32'h00000007, 32'h00000003, 32'h00000002, 32'h00000001};
		return i < 29 ? t[i] : 32'h0;
	endfunction

	task automatic rotate_heading(input longint ang, output longint c, output longint s);
		longint xr;
		longint yr;
		longint z;
		longint nx;
		bit flip;
		xr = longint'(GAIN_Q30);
		yr = 0;
		flip = 1'b0;
		if (ang > longint'(PI_Q))
			ang -= longint'(TWO_PI_Q);
		else if (ang < -longint'(PI_Q))
			ang += longint'(TWO_PI_Q);
		if (ang > longint'(HALF_PI_Q)) begin
			ang -= longint'(PI_Q);
			flip = 1'b1;
		end else if (ang < -longint'(HALF_PI_Q)) begin
			ang += longint'(PI_Q);
			flip = 1'b1;
		end
		z = ang;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = xr - (yr >>> i);
				yr = yr + (xr >>> i);
				z -= longint'(arctan_q28(i));
			end else begin
				nx = xr + (yr >>> i);
				yr = yr - (xr >>> i);
				z += longint'(arctan_q28(i));
			end
			xr = nx;
		end
		c = flip ? -xr : xr;
		s = flip ? -yr : yr;
	endtask

	task automatic predict_pose(input in_item_t it);
		longint tl, tr, dl, dr, travel, dth, c, s, th;
		logic [31:0] dl32, dr32;
		out_item_t o;
		travel = 0;
		if (it.mode) begin
			x_pos = 0;
			y_pos = 0;
			theta = 0;
		end else begin
			dl32 = it.left_count - 32'(last_l);
			dr32 = it.right_count - 32'(last_r);
			tl = longint'(signed'(dl32));
			tr = longint'(signed'(dr32));
			dl = tl * longint'(dpt);
			dr = tr * longint'(dpt);
			travel = sat_w((dr + dl) >>> 9, 40);
			dth = mul_shift_cap(dr - dl, longint'(itw), 28, longint'(TWO_PI_Q));
			rotate_heading(theta, c, s);
			x_pos = sat_w(x_pos + mul_shift_cap(travel, c, 30, longint'(1) <<< 47), 48);
			y_pos = sat_w(y_pos + mul_shift_cap(travel, s, 30, longint'(1) <<< 47), 48);
			th = theta + dth;
			if (th >= longint'(TWO_PI_Q))
				th -= longint'(TWO_PI_Q);
			else if (th <= -longint'(TWO_PI_Q))
				th += longint'(TWO_PI_Q);
			theta = th;
		end
		last_l = longint'(it.left_count);
		last_r = longint'(it.right_count);
		o.pos_x = x_pos[47:0];
		o.pos_y = y_pos[47:0];
		o.heading = theta[31:0];
		o.step_distance = travel[39:0];
		pose_q.push_back(o);
	endtask

	// valid stays up after the beat until the next falling edge decides what follows
	task automatic send_beat(input in_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pose(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pose_q.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_DIST_PER_TICK)
			dpt = val[27:0];
		else
			itw = val;
		@(negedge clk);
	endtask

	function automatic in_item_t make_item(bit m, logic [31:0] l, logic [31:0] r);
		in_item_t it;
		it.mode = m;
		it.left_count = l;
		it.right_count = r;
		return it;
	endfunction

	task automatic test_directed();
		send_beat(make_item(1'b0, 32'd100, 32'd100));
		send_beat(make_item(1'b0, 32'd300, 32'd100));
		send_beat(make_item(1'b0, 32'd300, 32'd900));
		// counter wrap across the signed boundary
		send_beat(make_item(1'b1, 32'h7FFF_FFF0, 32'h7FFF_FFF0));
		send_beat(make_item(1'b0, 32'h8000_0010, 32'h8000_0020));
		send_beat(make_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
		send_beat(make_item(1'b0, 32'h0, 32'hFFFF_FFFF));
		send_beat(make_item(1'b1, 32'hFFFF_FFFF, 32'h0));
		// big opposite turns: clamped heading change and heading wrap
		for (int i = 0; i < 6; i++)
			send_beat(make_item(1'b0, -32'(i * 40000), 32'(i * 40000)));
		for (int i = 0; i < 6; i++)
			send_beat(make_item(1'b0, 32'(i * 30000), -32'(i * 30000)));
		send_beat(make_item(1'b1, 32'h0, 32'h0));
	endtask

	// mostly small steps, some big jumps, occasional pose resets
	task automatic test_random(input int n);
		logic [31:0] l;
		logic [31:0] r;
		bit m;
		l = 32'(last_l);
		r = 32'(last_r);
		for (int i = 0; i < n; i++) begin
			m = ($urandom_range(19) == 0);
			case ($urandom_range(9))
				0: begin
					l = $urandom();
					r = $urandom();
				end
				1: begin
					l = l + 32'($urandom_range(4000)) - 32'd2000;
					r = r + 32'($urandom_range(200));
				end
				default: begin
					l = l + 32'($urandom_range(400)) - 32'd100;
					r = r + 32'($urandom_range(400)) - 32'd100;
				end
			endcase
			send_beat(make_item(m, l, r));
		end
	endtask

	task automatic test_config(input logic [31:0] d, input logic [31:0] t, input int n);
		wait_drained();
		write_reg(REG_DIST_PER_TICK, d);
		write_reg(REG_INV_TRACK_WIDTH, t);
		cfg_valid <= 1'b0;
		test_random(n);
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pose_q.size() == 0) begin
				$error("result beat with nothing expected");
				fail_cnt++;
			end else begin
				e = pose_q.pop_front();
				if (out_data.pos_x !== e.pos_x) begin
					$error("pos_x exp %0d got %0d", e.pos_x, out_data.pos_x);
					fail_cnt++;
				end
				if (out_data.pos_y !== e.pos_y) begin
					$error("pos_y exp %0d got %0d", e.pos_y, out_data.pos_y);
					fail_cnt++;
				end
				if (out_data.heading !== e.heading) begin
					$error("heading exp %0d got %0d", e.heading, out_data.heading);
					fail_cnt++;
				end
				if (out_data.step_distance !== e.step_distance) begin
					$error("step_distance exp %0d got %0d", e.step_distance,
						out_data.step_distance);
					fail_cnt++;
				end
			end
		end
	end

	always @(negedge clk)
		out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| all_sent && pose_q.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("differential_drive_odometry regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_cnt = 0;
		idle_cycles = 0;
		all_sent = 1'b0;
		dpt = DPT_RESET;
		itw = ITW_RESET;
		last_l = 0;
		last_r = 0;
		x_pos = 0;
		y_pos = 0;
		theta = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(120);
		send_idle_pct = 61;
		test_config(32'h0FFF_FFFF, 32'hFFFF_FFFF, 60);
		recv_stall_pct = 61;
		send_idle_pct = 0;
		test_config(32'h0, 32'h0, 40);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		test_config(32'd16777216, 32'd85899345, 120);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_config($urandom() & 32'h0FFF_FFFF, $urandom(), 100);
		all_sent = 1'b1;
		wait_drained();
		if (fail_cnt == 0)
			$display("differential_drive_odometry regression: pass");
		else
			$display("differential_drive_odometry regression: fail");
		$finish;
	end

endmodule
